>>> design/mbrc_pkg.sv
// Shared types, constants and the byte-wide CRC-16 update for the reply checker.
`timescale 1ns / 1ps
`default_nettype none
package mbrc_pkg;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic [7:0]  FUNC_READ    = 8'h03;
   localparam logic [7:0]  FUNC_EXC_BIT = 8'h80;
   localparam logic [7:0]  CNT_MAX      = 8'hFF;

   localparam logic        REG_SLAVE_ADDRESS  = 1'b0;
   localparam logic        REG_REGISTER_COUNT = 1'b1;

   localparam logic        KIND_DATA    = 1'b0;
   localparam logic        KIND_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_OK       = 3'd0,
      VERDICT_EXC_GOOD = 3'd1,
      VERDICT_EXC_BAD  = 3'd2,
      VERDICT_LENGTH   = 3'd3,
      VERDICT_HEADER   = 3'd4,
      VERDICT_COUNT    = 3'd5,
      VERDICT_CRC      = 3'd6
   } verdict_type;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  data_byte;
      verdict_type verdict;
      logic [7:0]  exception_code;
   } result_type;

   // Eight reflected shift steps, unrolled.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> design/mbrc_csr.sv
// APB-style configuration registers: slave address and register count.
`timescale 1ns / 1ps
`default_nettype none
module mbrc_csr
   import mbrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic [7:0]       slave_address,
   output logic [6:0]       register_count
);

   logic [7:0] slave_address_ff, slave_address_in;
   logic [6:0] register_count_ff, register_count_in;
   logic       wr_en;
   logic       reg_sel;

   // Registers sit on word boundaries; the low address bits are not decoded.
   assign reg_sel    = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      slave_address_in  = slave_address_ff;
      register_count_in = register_count_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SLAVE_ADDRESS:  slave_address_in  = csr_pwdata[7:0];
            REG_REGISTER_COUNT: register_count_in = csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SLAVE_ADDRESS:  csr_prdata = {24'd0, slave_address_ff};
         REG_REGISTER_COUNT: csr_prdata = {25'd0, register_count_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff  <= 8'd1;
         register_count_ff <= 7'd1;
      end else begin
         slave_address_ff  <= slave_address_in;
         register_count_ff <= register_count_in;
      end
   end

   assign slave_address  = slave_address_ff;
   assign register_count = register_count_ff;

endmodule
`default_nettype wire

>>> design/mbrc_core.sv
// Frame state, running CRC and verdict logic; one received byte per transfer.
`timescale 1ns / 1ps
`default_nettype none
module mbrc_core
   import mbrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       consume,
   input  wire logic [7:0] rx_byte,
   input  wire logic       end_of_frame,
   input  wire logic [7:0] slave_address,
   input  wire logic [6:0] register_count,
   output result_type      res
);

   logic [7:0]  cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  third_ff, third_in;
   logic        given_ff, given_in;

   logic [7:0]  cnt_nx;
   logic [15:0] crc_nx;
   logic [7:0]  addr_nx, func_nx, third_nx;
   logic [8:0]  exp_len;
   logic [8:0]  data_end;
   logic        frame_done;
   logic        is_data;

   logic [7:0]  v_cnt, v_addr, v_func, v_third;
   logic [15:0] v_crc;
   verdict_type v_code;
   logic [7:0]  v_exc;

   assign exp_len  = 9'd5 + {1'b0, register_count, 1'b0};
   assign data_end = 9'd3 + {1'b0, register_count, 1'b0};

   assign cnt_nx   = (cnt_ff == CNT_MAX) ? CNT_MAX : cnt_ff + 8'd1;
   assign crc_nx   = crc_byte(crc_ff, rx_byte);
   assign addr_nx  = (cnt_ff == 8'd0) ? rx_byte : addr_ff;
   assign func_nx  = (cnt_ff == 8'd1) ? rx_byte : func_ff;
   assign third_nx = (cnt_ff == 8'd2) ? rx_byte : third_ff;

   assign frame_done = ({1'b0, cnt_nx} >= exp_len);
   assign is_data    = (cnt_ff >= 8'd3) && (cnt_ff != CNT_MAX)
                       && ({1'b0, cnt_ff} < data_end);

   // End marker judges what is held; a byte judges the state including itself.
   always_comb begin
      if (end_of_frame) begin
         v_cnt   = cnt_ff;
         v_crc   = crc_ff;
         v_addr  = addr_ff;
         v_func  = func_ff;
         v_third = third_ff;
      end else begin
         v_cnt   = cnt_nx;
         v_crc   = crc_nx;
         v_addr  = addr_nx;
         v_func  = func_nx;
         v_third = third_nx;
      end
   end

   always_comb begin
      v_exc = 8'd0;
      if (v_cnt == 8'd5 && v_func == (FUNC_EXC_BIT | FUNC_READ)) begin
         v_code = (v_crc == 16'd0) ? VERDICT_EXC_GOOD : VERDICT_EXC_BAD;
         v_exc  = v_third;
      end else if ({1'b0, v_cnt} != exp_len) begin
         v_code = VERDICT_LENGTH;
      end else if (v_addr != slave_address || v_func != FUNC_READ) begin
         v_code = VERDICT_HEADER;
      end else if (v_third != {register_count, 1'b0}) begin
         v_code = VERDICT_COUNT;
      end else if (v_crc != 16'd0) begin
         v_code = VERDICT_CRC;
      end else begin
         v_code = VERDICT_OK;
      end
   end

   always_comb begin
      res.valid          = 1'b0;
      res.kind           = KIND_VERDICT;
      res.data_byte      = 8'd0;
      res.verdict        = v_code;
      res.exception_code = v_exc;
      if (!given_ff) begin
         if (end_of_frame || frame_done) begin
            res.valid = 1'b1;
         end else if (is_data) begin
            res.valid          = 1'b1;
            res.kind           = KIND_DATA;
            res.data_byte      = rx_byte;
            res.verdict        = VERDICT_OK;
            res.exception_code = 8'd0;
         end
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      addr_in  = addr_ff;
      func_in  = func_ff;
      third_in = third_ff;
      given_in = given_ff;
      if (consume) begin
         if (end_of_frame) begin
            cnt_in   = 8'd0;
            crc_in   = CRC_INIT;
            addr_in  = 8'd0;
            func_in  = 8'd0;
            third_in = 8'd0;
            given_in = 1'b0;
         end else if (!given_ff) begin
            cnt_in   = cnt_nx;
            crc_in   = crc_nx;
            addr_in  = addr_nx;
            func_in  = func_nx;
            third_in = third_nx;
            given_in = frame_done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 8'd0;
         crc_ff   <= CRC_INIT;
         addr_ff  <= 8'd0;
         func_ff  <= 8'd0;
         third_ff <= 8'd0;
         given_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         third_ff <= third_in;
         given_ff <= given_in;
      end
   end

`ifndef SYNTH
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      consume && end_of_frame |=> !given_ff && cnt_ff == 8'd0 && crc_ff == CRC_INIT)
      else $error("end marker did not rearm the checker");

   a_quiet_after_verdict: assert property (@(posedge clock) disable iff (reset)
      given_ff && !end_of_frame |-> !res.valid)
      else $error("result produced after the verdict");

   a_exc_code_zero: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.verdict != VERDICT_EXC_GOOD && res.verdict != VERDICT_EXC_BAD
      |-> res.exception_code == 8'd0)
      else $error("exception code set on a non-exception result");

   a_verdict_sets_given: assert property (@(posedge clock) disable iff (reset)
      consume && !end_of_frame && res.valid && res.kind == KIND_VERDICT |=> given_ff)
      else $error("verdict on a byte did not close the frame");
`endif

endmodule
`default_nettype wire

>>> design/modbus_read_response_checker.sv
// Top level: input register, frame checker core, result register and CSRs.
// A result passes from its request transfer through the input register and the
// result register to rsp_*.
// Throughput: one received byte per cycle unless the result register stalls; the CRC byte
// update and verdict compare between the input and result registers set this rate.
// A stalled result register holds the input register, which then stalls req.
// Reset (synchronous, active high) empties both registers, rearms the frame
// state and sets slave_address and register_count to 1.
`timescale 1ns / 1ps
`default_nettype none
module modbus_read_response_checker
   import mbrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_end_of_frame,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_result_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [2:0]       rsp_verdict,
   output logic [7:0]       rsp_exception_code,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_eof_ff, in_eof_in;
   logic       out_vld_ff, out_vld_in;
   result_type out_res_ff, out_res_in;

   logic       req_xfer;
   logic       out_free;
   logic       consume;
   logic [7:0] slave_address;
   logic [6:0] register_count;
   result_type core_res;

   mbrc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .slave_address  (slave_address),
      .register_count (register_count)
   );

   mbrc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .consume        (consume),
      .rx_byte        (in_byte_ff),
      .end_of_frame   (in_eof_ff),
      .slave_address  (slave_address),
      .register_count (register_count),
      .res            (core_res)
   );

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign consume   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      in_eof_in  = in_eof_ff;
      if (req_xfer) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_rx_byte;
         in_eof_in  = req_end_of_frame;
      end else if (consume) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      out_res_in = out_res_ff;
      if (out_free) begin
         out_vld_in = consume && core_res.valid;
         if (consume && core_res.valid) begin
            out_res_in = core_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eof_ff  <= in_eof_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_result_kind    = out_res_ff.kind;
   assign rsp_data_byte      = out_res_ff.data_byte;
   assign rsp_verdict        = out_res_ff.verdict;
   assign rsp_exception_code = out_res_ff.exception_code;

`ifndef SYNTH
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_stall |-> !consume)
      else $error("input consumed while the result register is blocked");

   a_load: assert property (@(posedge clock) disable iff (reset)
      consume && core_res.valid |=> out_vld_ff)
      else $error("result lost on its way to the result register");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !consume |=> in_vld_ff && $stable(in_byte_ff) && $stable(in_eof_ff))
      else $error("input register changed while waiting");
`endif

endmodule
`default_nettype wire

>>> tb/tb_modbus_read_response_checker.sv
// Self-checking testbench for the Modbus read-reply checker: frames, verdicts, data and CSRs.
`timescale 1ns / 1ps
module tb_modbus_read_response_checker;
   import mbrc_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LONG_HOLD    = 150;
   localparam int RANDOM_ITEMS = 1000;
   localparam int SETTLE       = 4;

   localparam logic [2:0] ADDR_SLAVE_ADDRESS  = {REG_SLAVE_ADDRESS, 2'b00};
   localparam logic [2:0] ADDR_REGISTER_COUNT = {REG_REGISTER_COUNT, 2'b00};
   localparam logic [7:0] FUNC_EXCEPTION      = FUNC_EXC_BIT | FUNC_READ;

   typedef struct {
      logic        kind;
      logic [7:0]  data_byte;
      verdict_type verdict;
      logic [7:0]  exception_code;
   } reply_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_end_of_frame = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic [2:0]  rsp_verdict;
   logic [7:0]  rsp_exception_code;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of registers and frame state
   logic [7:0]  cfg_slave_address = 8'd1;
   logic [6:0]  cfg_register_count = 7'd1;
   logic [7:0]  frame_len = 8'd0;
   logic [15:0] frame_crc = CRC_INIT;
   logic [7:0]  seen_address = 8'd0;
   logic [7:0]  seen_function = 8'd0;
   logic [7:0]  seen_third = 8'd0;
   logic        verdict_done = 1'b0;

   reply_item_type pending_replies[$];
   logic [7:0]  frame_buf[$];

   int fail_count = 0;
   int cycle_count = 0;
   int live_items = 0;
   int send_idle_pct = 30;
   int recv_idle_pct = 30;
   int long_hold_req = 0;
   int hold_served = 0;
   int stall_left = 0;

   modbus_read_response_checker dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------- prediction ----------------

   function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
      return r;
   endfunction

   function automatic int reply_length();
      return 5 + 2 * int'(cfg_register_count);
   endfunction

   task automatic push_verdict();
      reply_item_type r;
      r.kind = KIND_VERDICT;
      r.data_byte = 8'h00;
      r.exception_code = 8'h00;
      if (frame_len == 8'd5 && seen_function == FUNC_EXCEPTION) begin
         r.verdict = (frame_crc == 16'h0000) ? VERDICT_EXC_GOOD : VERDICT_EXC_BAD;
         r.exception_code = seen_third;
      end else if (int'(frame_len) != reply_length()) begin
         r.verdict = VERDICT_LENGTH;
      end else if (seen_address != cfg_slave_address || seen_function != FUNC_READ) begin
         r.verdict = VERDICT_HEADER;
      end else if (int'(seen_third) != 2 * int'(cfg_register_count)) begin
         r.verdict = VERDICT_COUNT;
      end else if (frame_crc != 16'h0000) begin
         r.verdict = VERDICT_CRC;
      end else begin
         r.verdict = VERDICT_OK;
      end
      pending_replies.push_back(r);
   endtask

   task automatic track_frame(input logic [7:0] b, input logic eof);
      int pos;
      reply_item_type r;
      if (eof) begin
         if (!verdict_done) push_verdict();
         frame_len = 8'd0;
         frame_crc = CRC_INIT;
         seen_address = 8'd0;
         seen_function = 8'd0;
         seen_third = 8'd0;
         verdict_done = 1'b0;
      end else if (!verdict_done) begin
         pos = int'(frame_len);
         case (pos)
            0: seen_address = b;
            1: seen_function = b;
            2: seen_third = b;
            default: ;
         endcase
         frame_crc = crc16_step(frame_crc, b);
         if (frame_len != CNT_MAX) frame_len = frame_len + 8'd1;
         if (int'(frame_len) >= reply_length()) begin
            verdict_done = 1'b1;
            push_verdict();
         end else if (pos >= 3 && pos < 255 && pos < 3 + 2 * int'(cfg_register_count)) begin
            r.kind = KIND_DATA;
            r.data_byte = b;
            r.verdict = VERDICT_OK;
            r.exception_code = 8'h00;
            pending_replies.push_back(r);
         end
      end
   endtask

   // ---------------- result side ----------------

   always @(posedge clock) begin : rsp_throttle
      int w;
      if (hold_served != long_hold_req) begin
         hold_served <= long_hold_req;
         stall_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end else if (rsp_valid === 1'b1 && !rsp_stall) begin
         w = ($urandom_range(0, 99) < recv_idle_pct) ? $urandom_range(1, 18) : 0;
         stall_left <= w;
         rsp_stall <= (w > 0);
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      reply_item_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_replies.size() == 0) begin
            $error("result transfer with nothing expected (kind %0d)", rsp_result_kind);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            check_field("result_kind", 8'(want.kind), 8'(rsp_result_kind));
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("verdict", 8'(want.verdict), 8'(rsp_verdict));
            check_field("exception_code", want.exception_code, rsp_exception_code);
         end
      end
   end

   // ---------------- request side ----------------

   task automatic send_item(input logic [7:0] b, input logic eof);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 18) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_end_of_frame <= eof;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (eof || !verdict_done) live_items++;
      track_frame(b, eof);
   endtask

   task automatic send_eof();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_buf(input bit with_eof);
      foreach (frame_buf[i]) send_item(frame_buf[i], 1'b0);
      if (with_eof) send_eof();
   endtask

   // Wait until every expected result is in, then let the pipeline empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= (index == REG_SLAVE_ADDRESS) ? ADDR_SLAVE_ADDRESS : ADDR_REGISTER_COUNT;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == REG_SLAVE_ADDRESS) cfg_slave_address = value[7:0];
      else cfg_register_count = value[6:0];
   endtask

   // Reply body without CRC; fill < 0 means random data.
   task automatic build_reply(input logic [7:0] addr, input logic [7:0] func,
                              input logic [7:0] count_byte, input int nregs, input int fill);
      frame_buf.delete();
      frame_buf.push_back(addr);
      frame_buf.push_back(func);
      frame_buf.push_back(count_byte);
      repeat (2 * nregs)
         frame_buf.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
   endtask

   task automatic append_crc();
      logic [15:0] c;
      c = CRC_INIT;
      foreach (frame_buf[i]) c = crc16_step(c, frame_buf[i]);
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
   endtask

   task automatic build_good(input int fill);
      build_reply(cfg_slave_address, FUNC_READ, 8'(2 * cfg_register_count),
                  cfg_register_count, fill);
      append_crc();
   endtask

   task automatic build_exception(input logic [7:0] addr, input logic [7:0] code);
      frame_buf.delete();
      frame_buf.push_back(addr);
      frame_buf.push_back(FUNC_EXCEPTION);
      frame_buf.push_back(code);
      append_crc();
   endtask

   task automatic flip_byte(input int k);
      frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
   endtask

   // ---------------- tests ----------------

   task automatic test_good_replies();
      build_good(8'h00);
      send_buf(1);
      build_good(8'hFF);
      send_buf(1);
      build_good(-1);
      send_buf(1);
      drain();
   endtask

   task automatic test_exception_replies();
      build_exception(cfg_slave_address, 8'h02);
      send_buf(1);
      build_exception(cfg_slave_address, 8'hFF);
      flip_byte(4);
      send_buf(1);
      build_exception(8'hA5, 8'h00);
      send_buf(1);
      drain();
   endtask

   task automatic test_malformed_replies();
      int k;
      for (k = 0; k < 3; k++) begin
         // address, function or byte count wrong in turn, CRC recomputed
         build_reply(cfg_slave_address, FUNC_READ, 8'(2 * cfg_register_count),
                     cfg_register_count, -1);
         flip_byte(k);
         append_crc();
         send_buf(1);
      end
      build_good(-1);
      flip_byte(frame_buf.size() - 2);
      send_buf(1);
      build_good(-1);
      repeat (4) void'(frame_buf.pop_back());
      send_buf(1);
      drain();
   endtask

   task automatic test_end_markers();
      send_eof();
      send_eof();
      build_good(-1);
      repeat (3) frame_buf.push_back(8'($urandom_range(0, 255)));
      send_buf(1);
      build_good(-1);
      frame_buf = frame_buf[0:3];
      send_buf(1);
      drain();
   endtask

   task automatic test_register_extremes();
      write_reg(REG_SLAVE_ADDRESS, 32'd0);
      build_good(-1);
      send_buf(1);
      drain();
      write_reg(REG_SLAVE_ADDRESS, 32'd255);
      write_reg(REG_REGISTER_COUNT, 32'd0);
      build_good(-1);
      send_buf(1);
      build_exception(cfg_slave_address, 8'h04);
      send_buf(1);
      drain();
      write_reg(REG_REGISTER_COUNT, 32'd125);
      build_good(-1);
      send_buf(1);
      drain();
      // expected length beyond the saturating counter: only the end marker closes it
      write_reg(REG_REGISTER_COUNT, 32'd126);
      build_good(-1);
      send_buf(1);
      drain();
      write_reg(REG_REGISTER_COUNT, 32'd127);
      build_good(-1);
      repeat (10) void'(frame_buf.pop_back());
      send_buf(1);
      drain();
      write_reg(REG_SLAVE_ADDRESS, 32'd1);
      write_reg(REG_REGISTER_COUNT, 32'd1);
   endtask

   task automatic test_mid_frame_change();
      int k;
      write_reg(REG_REGISTER_COUNT, 32'd4);
      build_good(-1);
      for (k = 0; k < 6; k++) send_item(frame_buf[k], 1'b0);
      drain();
      // shorter length now: the next byte closes the frame
      write_reg(REG_REGISTER_COUNT, 32'd1);
      for (k = 6; k < frame_buf.size(); k++) send_item(frame_buf[k], 1'b0);
      send_eof();
      drain();
      write_reg(REG_REGISTER_COUNT, 32'd2);
      build_good(-1);
      for (k = 0; k < 4; k++) send_item(frame_buf[k], 1'b0);
      drain();
      write_reg(REG_REGISTER_COUNT, 32'd3);
      for (k = 4; k < frame_buf.size(); k++) send_item(frame_buf[k], 1'b0);
      send_eof();
      drain();
      write_reg(REG_REGISTER_COUNT, 32'd2);
      build_good(-1);
      for (k = 0; k < 3; k++) send_item(frame_buf[k], 1'b0);
      drain();
      write_reg(REG_SLAVE_ADDRESS, 32'(cfg_slave_address + 8'd1));
      for (k = 3; k < frame_buf.size(); k++) send_item(frame_buf[k], 1'b0);
      send_eof();
      drain();
      write_reg(REG_SLAVE_ADDRESS, 32'd1);
   endtask

   task automatic test_backpressure();
      int saved_send;
      saved_send = send_idle_pct;
      write_reg(REG_REGISTER_COUNT, 32'd8);
      send_idle_pct = 0;
      long_hold_req++;
      repeat (2) begin
         build_good(-1);
         send_buf(1);
      end
      drain();
      send_idle_pct = saved_send;
   endtask

   task automatic random_config();
      int r;
      drain();
      r = $urandom_range(0, 9);
      write_reg(REG_SLAVE_ADDRESS, (r == 0) ? 32'd0 : (r == 1) ? 32'd255 : $urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 3) write_reg(REG_REGISTER_COUNT, 32'd0);
      else if (r < 5) write_reg(REG_REGISTER_COUNT, 32'd125);
      else if (r < 7) write_reg(REG_REGISTER_COUNT, $urandom_range(126, 127));
      else if (r < 15) write_reg(REG_REGISTER_COUNT, $urandom_range(9, 40));
      else write_reg(REG_REGISTER_COUNT, $urandom_range(1, 8));
      r = $urandom_range(0, 2);
      send_idle_pct = (r == 0) ? 0 : (r == 1) ? 20 : 60;
      r = $urandom_range(0, 2);
      recv_idle_pct = (r == 0) ? 0 : (r == 1) ? 20 : 60;
   endtask

   task automatic random_frame();
      int choice;
      int m;
      int k;
      choice = $urandom_range(0, 99);
      if (choice < 15) begin
         frame_buf.delete();
         repeat ($urandom_range(0, 12)) frame_buf.push_back(8'($urandom_range(0, 255)));
      end else if (choice < 25) begin
         build_exception(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : cfg_slave_address,
                         8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) flip_byte($urandom_range(0, 4));
      end else begin
         m = $urandom_range(0, 11);
         build_reply(cfg_slave_address, FUNC_READ, 8'(2 * cfg_register_count),
                     cfg_register_count, -1);
         if (m < 3) flip_byte(m);
         append_crc();
         if (m == 3) flip_byte($urandom_range(3, frame_buf.size() - 1));
         if (m == 4) begin
            k = $urandom_range(1, frame_buf.size());
            repeat (k) void'(frame_buf.pop_back());
         end
         if (m == 5) repeat ($urandom_range(1, 6))
            frame_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_buf($urandom_range(0, 19) != 0);
   endtask

   task automatic test_random_traffic();
      int start;
      start = live_items;
      while (live_items - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) random_config();
         random_frame();
      end
      send_eof();
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_good_replies();
      test_exception_replies();
      test_malformed_replies();
      test_end_markers();
      test_register_extremes();
      test_mid_frame_change();
      test_backpressure();
      test_random_traffic();
      repeat (20) @(posedge clock);
      if (pending_replies.size() != 0) begin
         $error("%0d expected results never arrived", pending_replies.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
